>>> hw/rtl/cak_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crop and alpha key package
// Shared types, register indexes, keying modes and the saturate and window clamp functions.
// ----------------------------------------------------------------------------
package cak_pkg;

	// Largest image dimension and the widths that follow from it.
	localparam int MAX_DIM = 4096;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = CNT_W + 1;
	localparam int END_W   = DIM_W + 1;

	localparam logic [DIM_W-1:0] DIM_SAT = DIM_W'(MAX_DIM);

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_SRC_WIDTH   = 3'd0,
		REG_SRC_HEIGHT  = 3'd1,
		REG_CROP_X      = 3'd2,
		REG_CROP_Y      = 3'd3,
		REG_CROP_WIDTH  = 3'd4,
		REG_CROP_HEIGHT = 3'd5,
		REG_KEY_MODE    = 3'd6,
		REG_KEY_LEVEL   = 3'd7
	} cak_reg_t;

	// Alpha handling modes; the spare code passes the pixel through.
	localparam logic [1:0] MODE_KEEP   = 2'd0;
	localparam logic [1:0] MODE_WHITE  = 2'd1;
	localparam logic [1:0] MODE_THRESH = 2'd2;

	// Luma weights in Q16 with the rounding offset.
	localparam logic [23:0] LUMA_R   = 24'd19595;
	localparam logic [23:0] LUMA_G   = 24'd38470;
	localparam logic [23:0] LUMA_B   = 24'd7471;
	localparam logic [23:0] LUMA_RND = 24'd32768;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} cak_pix_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       end_of_row;
		logic       last_of_crop;
	} cak_res_t;

	typedef struct packed {
		logic [12:0] src_width;
		logic [12:0] src_height;
		logic [12:0] crop_x;
		logic [12:0] crop_y;
		logic [12:0] crop_width;
		logic [12:0] crop_height;
		logic [1:0]  key_mode;
		logic [7:0]  key_level;
	} cak_cfg_t;

	// One clamped axis: first position and one past the last position.
	typedef struct packed {
		logic [DIM_W-1:0] start;
		logic [END_W-1:0] stop;
	} cak_axis_t;

	// Where the current source pixel falls in the window.
	typedef struct packed {
		logic hit;
		logic eor;
		logic last;
	} cak_pos_t;

	// Saturate a source dimension to the largest supported size.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [12:0] v);
		logic [DIM_W-1:0] r;
		r = (DIM_W'(v) > DIM_SAT) ? DIM_SAT : DIM_W'(v);
		return r;
	endfunction

	// Clamp a window start and length against one image dimension.
	function automatic cak_axis_t clamp_axis(input logic [DIM_W-1:0] dim,
	                                         input logic [12:0] start,
	                                         input logic [12:0] len);
		cak_axis_t        a;
		logic [DIM_W-1:0] s;
		logic [DIM_W-1:0] room;
		logic [DIM_W-1:0] l;
		s    = (DIM_W'(start) > dim) ? dim : DIM_W'(start);
		room = dim - s;
		l    = (DIM_W'(len) > room) ? room : DIM_W'(len);
		if (room == '0) begin
			l = '0;
		end else if (l == '0) begin
			l = DIM_W'(1);
		end
		a.start = s;
		a.stop  = END_W'(s) + END_W'(l);
		return a;
	endfunction

endpackage

>>> hw/rtl/cak_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crop window locator
// Clamps the crop window to the image and places the current pixel in it.
// ----------------------------------------------------------------------------
module cak_window import cak_pkg::*; (
	input  cak_cfg_t         cfg,
	input  logic [CNT_W-1:0] col,
	input  logic [CNT_W-1:0] row,
	output logic [DIM_W-1:0] w_img,
	output logic [DIM_W-1:0] h_img,
	output cak_pos_t         pos
);

	cak_axis_t        ax_x;
	cak_axis_t        ax_y;
	logic [END_W-1:0] col_next;
	logic [END_W-1:0] row_next;
	logic             col_in;
	logic             row_in;

	// Effective image size and the clamped window on both axes.
	always_comb begin
		w_img = sat_dim(cfg.src_width);
		h_img = sat_dim(cfg.src_height);
		ax_x  = clamp_axis(w_img, cfg.crop_x, cfg.crop_width);
		ax_y  = clamp_axis(h_img, cfg.crop_y, cfg.crop_height);
	end

	// An empty axis has stop equal to start, so nothing falls inside it.
	always_comb begin
		col_next = END_W'(col) + END_W'(1);
		row_next = END_W'(row) + END_W'(1);
		col_in   = (DIM_W'(col) >= ax_x.start) && (END_W'(col) < ax_x.stop);
		row_in   = (DIM_W'(row) >= ax_y.start) && (END_W'(row) < ax_y.stop);
		pos.hit  = col_in && row_in;
		pos.eor  = (col_next == ax_x.stop);
		pos.last = pos.eor && (row_next == ax_y.stop);
	end

endmodule

>>> hw/rtl/cak_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha keyer
// Applies pass-through, white keying or black luma thresholding to a pixel.
// ----------------------------------------------------------------------------
module cak_key import cak_pkg::*; (
	input  cak_pix_t   pix,
	input  logic [1:0] key_mode,
	input  logic [7:0] key_level,
	input  cak_pos_t   pos,
	output cak_res_t   res
);

	logic [23:0] luma_sum;
	logic [7:0]  luma;
	logic        white;

	// Q16 luma; the rounded sum stays below 2^24.
	always_comb begin
		luma_sum = ({16'd0, pix.red} * LUMA_R) + ({16'd0, pix.green} * LUMA_G)
		         + ({16'd0, pix.blue} * LUMA_B) + LUMA_RND;
		luma     = luma_sum[23:16];
		white    = (~pix.red <= key_level) && (~pix.green <= key_level)
		        && (~pix.blue <= key_level);
	end

	// Select the result colour and alpha by mode.
	always_comb begin
		res.out_red      = pix.red;
		res.out_green    = pix.green;
		res.out_blue     = pix.blue;
		res.out_alpha    = pix.alpha;
		res.end_of_row   = pos.eor;
		res.last_of_crop = pos.last;
		case (key_mode)
			MODE_WHITE: begin
				if (white) begin
					res.out_alpha = 8'd0;
				end
			end
			MODE_THRESH: begin
				if (luma <= key_level) begin
					res.out_red   = 8'd0;
					res.out_green = 8'd0;
					res.out_blue  = 8'd0;
					res.out_alpha = 8'd255;
				end else begin
					res.out_alpha = 8'd0;
				end
			end
			default: begin
				res.out_alpha = pix.alpha;
			end
		endcase
	end

endmodule

>>> hw/rtl/crop_alpha_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crop and alpha key
// Crops a raster-order RGBA stream to a window and keys the alpha channel.
// ----------------------------------------------------------------------------
// Source pixels enter on the pix channel in raster order, one transfer per
// pixel; the block counts column and row itself. Each pixel inside the
// clamped crop window leaves as one transfer on the res channel, flagged at
// the end of each window row and at the last window pixel. Pixels outside
// the window are consumed and give no transfer.
// The cfg channel writes one register per transfer and is always ready.
// Write it only while no pixel is in flight.
// A pixel passes two registered stages on its way from pix to res: an input
// stage holds the pixel and its window position, an output register holds
// the keyed result. One pixel is taken every cycle while res is not stalled.
// When res_stall is high a full output holds; pix_stall rises only once both
// stages are full, so one more pixel can be taken during a stall.
// Reset clears both counters, empties the stages and loads the register
// defaults: 1x1 image, 1x1 window at the origin, alpha kept, level zero.
// ----------------------------------------------------------------------------
module crop_alpha_key import cak_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  cak_pix_t    pix,
	output logic        res_valid,
	input  logic        res_stall,
	output cak_res_t    res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cak_reg_t    cfg_index,
	input  logic [12:0] cfg_data
);

	cak_cfg_t         cfg_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] w_img;
	logic [DIM_W-1:0] h_img;
	cak_pos_t         pos;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             pix_acc;
	logic             s1_go;
	logic             valid_s1;
	cak_pix_t         pix_s1;
	cak_pos_t         pos_s1;
	cak_res_t         key_res;
	cak_res_t         res_s2;
	logic             valid_s2;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width   <= 13'd1;
			cfg_q.src_height  <= 13'd1;
			cfg_q.crop_x      <= 13'd0;
			cfg_q.crop_y      <= 13'd0;
			cfg_q.crop_width  <= 13'd1;
			cfg_q.crop_height <= 13'd1;
			cfg_q.key_mode    <= MODE_KEEP;
			cfg_q.key_level   <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data;
				REG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data;
				REG_CROP_X:      cfg_q.crop_x      <= cfg_data;
				REG_CROP_Y:      cfg_q.crop_y      <= cfg_data;
				REG_CROP_WIDTH:  cfg_q.crop_width  <= cfg_data;
				REG_CROP_HEIGHT: cfg_q.crop_height <= cfg_data;
				REG_KEY_MODE:    cfg_q.key_mode    <= cfg_data[1:0];
				REG_KEY_LEVEL:   cfg_q.key_level   <= cfg_data[7:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	cak_window u_window (
		.cfg   (cfg_q),
		.col   (col_q),
		.row   (row_q),
		.w_img (w_img),
		.h_img (h_img),
		.pos   (pos)
	);

	// Pipeline handshake: the input stage moves when the output is free.
	always_comb begin
		s1_go     = !valid_s2 || !res_stall;
		pix_stall = valid_s1 && !s1_go;
		pix_acc   = pix_valid && !pix_stall;
		col_inc   = DIM_W'(col_q) + DIM_W'(1);
		row_inc   = DIM_W'(row_q) + DIM_W'(1);
	end

	// Raster position of the next source pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_inc >= w_img) begin
				col_q <= '0;
				row_q <= (row_inc >= h_img) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	// Input stage: loads when it is empty or moving on; only pixels inside
	// the window are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pix_stall) begin
			valid_s1 <= pix_acc && pos.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (!pix_stall) begin
			pix_s1 <= pix;
			pos_s1 <= pos;
		end
	end

	cak_key u_key (
		.pix       (pix_s1),
		.key_mode  (cfg_q.key_mode),
		.key_level (cfg_q.key_level),
		.pos       (pos_s1),
		.res       (key_res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_go) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			res_s2 <= key_res;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// The last window pixel always closes a window row.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!res.last_of_crop || res.end_of_row))
		else $error("last_of_crop without end_of_row");

	// With an empty output register the input is never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !pix_stall)
		else $error("pix_stall while output register empty");

	// Threshold mode gives only fully opaque black or fully clear pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cfg_q.key_mode == MODE_THRESH) |->
		(res.out_alpha == 8'd0 || res.out_alpha == 8'd255))
		else $error("threshold alpha neither 0 nor 255");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cfg_q.key_mode == MODE_THRESH && res.out_alpha == 8'd255) |->
		(res.out_red == 8'd0 && res.out_green == 8'd0 && res.out_blue == 8'd0))
		else $error("threshold dark pixel not black");

	// A full pipeline under stall takes no pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && res_stall) |-> pix_stall)
		else $error("pixel accepted into a full pipeline");

endmodule
